/* src/vic_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the vectored interrupt controller.
// No dependencies; imported by every module of the block.
package vic_pkg;

    localparam int NUM_SOURCES_DEF = 64;   // default number of interrupt sources
    localparam int MAX_SOURCES     = 64;   // width of the source and mask fields
    localparam int HALF_W          = 32;   // bus register width
    localparam int OFFSET_W        = 7;
    localparam int SEL_W           = 4;
    localparam int PIDX_W          = 6;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 64;
    localparam int IN_TDATA_W      = 104;
    localparam int IN_TUSER_W      = 2;
    localparam int OUT_TDATA_W     = 48;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_IDLE  = 2'd3
    } t_action;

    // register select, byte offset bits 6..3
    localparam logic [SEL_W-1:0] SEL_IRQ_STATUS  = 4'h0;
    localparam logic [SEL_W-1:0] SEL_FIQ_STATUS  = 4'h1;
    localparam logic [SEL_W-1:0] SEL_RAW_STATUS  = 4'h2;
    localparam logic [SEL_W-1:0] SEL_FIQ_SELECT  = 4'h3;
    localparam logic [SEL_W-1:0] SEL_ENABLE      = 4'h4;
    localparam logic [SEL_W-1:0] SEL_ENABLE_CLR  = 4'h5;
    localparam logic [SEL_W-1:0] SEL_SOFT        = 4'h6;
    localparam logic [SEL_W-1:0] SEL_SOFT_CLR    = 4'h7;
    localparam logic [SEL_W-1:0] SEL_LEVEL_SENSE = 4'h8;
    localparam logic [SEL_W-1:0] SEL_EDGE_CLR    = 4'hB;
    localparam logic [SEL_W-1:0] SEL_EDGE_STATUS = 4'hC;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_SENSE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIQ_SELECT  = 1'b1;

    typedef struct packed {
        t_action                action;
        logic [MAX_SOURCES-1:0] source_levels;
        logic [HALF_W-1:0]      write_data;
        logic [OFFSET_W-1:0]    reg_offset;
    } t_item;

    // read_data in the low bits
    typedef struct packed {
        logic              pending_valid;
        logic [PIDX_W-1:0] pending_index;
        logic              fiq_line;
        logic              irq_line;
        logic [HALF_W-1:0] read_data;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

/* src/vic_core.sv */
`timescale 1ns / 1ps
// Interrupt state, bus register file and status computation.
// Depends on vic_pkg.
module vic_core #(
    parameter int NUM_SOURCES = vic_pkg::NUM_SOURCES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [vic_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vic_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_accept,
    input  vic_pkg::t_item                   i_item,
    output logic [vic_pkg::HALF_W-1:0]       o_read_data,
    output logic                             o_irq_line,
    output logic                             o_fiq_line,
    output logic [NUM_SOURCES-1:0]           o_irq_vec
);
    import vic_pkg::*;

    localparam int N = NUM_SOURCES;

    logic [N-1:0] r_level, r_fiq, r_enable, r_soft, r_edge, r_prev;
    logic [N-1:0] n_enable, n_soft, n_edge, n_prev;

    logic [N-1:0]           w_levels, w_bits, w_raw, w_irq, w_fiq;
    logic [MAX_SOURCES-1:0] w_bits_wide, w_reg_wide;
    logic [SEL_W-1:0]       w_sel;
    logic [HALF_W-1:0]      w_rd;

    assign w_levels    = i_item.source_levels[N-1:0];
    assign w_sel       = i_item.reg_offset[OFFSET_W-1:3];
    assign w_bits_wide = i_item.reg_offset[2] ? {i_item.write_data, {HALF_W{1'b0}}}
                                              : {{HALF_W{1'b0}}, i_item.write_data};
    assign w_bits      = w_bits_wide[N-1:0];

    // next state
    always_comb begin
        n_enable = r_enable;
        n_soft   = r_soft;
        n_edge   = r_edge;
        n_prev   = r_prev;
        if (i_accept) begin
            case (i_item.action)
                ACT_TICK: begin
                    // rising edge on an edge-sensed source sets its latch
                    n_edge = r_edge | (w_levels & ~r_prev & ~r_level);
                    n_prev = w_levels;
                end
                ACT_WRITE: begin
                    case (w_sel)
                        SEL_ENABLE:     n_enable = r_enable | w_bits;
                        SEL_ENABLE_CLR: n_enable = r_enable & ~w_bits;
                        SEL_SOFT:       n_soft   = r_soft | w_bits;
                        SEL_SOFT_CLR:   n_soft   = r_soft & ~w_bits;
                        SEL_EDGE_CLR:   n_edge   = r_edge & ~w_bits;
                        default:        ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // status after the transaction has taken effect
    assign w_raw = (n_prev & r_level) | n_edge | n_soft;
    assign w_irq = w_raw & n_enable & ~r_fiq;
    assign w_fiq = w_raw & n_enable & r_fiq;

    always_comb begin
        case (w_sel)
            SEL_IRQ_STATUS:  w_reg_wide = MAX_SOURCES'(w_irq);
            SEL_FIQ_STATUS:  w_reg_wide = MAX_SOURCES'(w_fiq);
            SEL_RAW_STATUS:  w_reg_wide = MAX_SOURCES'(w_raw);
            SEL_FIQ_SELECT:  w_reg_wide = MAX_SOURCES'(r_fiq);
            SEL_ENABLE:      w_reg_wide = MAX_SOURCES'(n_enable);
            SEL_SOFT:        w_reg_wide = MAX_SOURCES'(n_soft);
            SEL_LEVEL_SENSE: w_reg_wide = MAX_SOURCES'(r_level);
            SEL_EDGE_STATUS: w_reg_wide = MAX_SOURCES'(n_edge);
            default:         w_reg_wide = '0;
        endcase
        w_rd = i_item.reg_offset[2] ? w_reg_wide[MAX_SOURCES-1:HALF_W]
                                    : w_reg_wide[HALF_W-1:0];
    end

    assign o_read_data = (i_item.action == ACT_READ) ? w_rd : '0;
    assign o_irq_line  = |w_irq;
    assign o_fiq_line  = |w_fiq;
    assign o_irq_vec   = w_irq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_fiq    <= '0;
            r_enable <= '0;
            r_soft   <= '0;
            r_edge   <= '0;
            r_prev   <= '0;
        end else begin
            r_enable <= n_enable;
            r_soft   <= n_soft;
            r_edge   <= n_edge;
            r_prev   <= n_prev;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LEVEL_SENSE: r_level <= i_cfg_wdata[N-1:0];
                    CFG_FIQ_SELECT:  r_fiq   <= i_cfg_wdata[N-1:0];
                    default:         ;
                endcase
            end
        end
    end

    a_tick_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.action == ACT_TICK) |=> (r_prev == $past(w_levels)))
        else $error("previous levels not taken on tick");

    a_edge_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.action == ACT_WRITE && w_sel == SEL_EDGE_CLR)
        |=> ((r_edge & $past(w_bits)) == '0))
        else $error("edge latch bit survived write-1 clear");

    a_cfg_fiq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index == CFG_FIQ_SELECT) |=> (r_fiq == $past(i_cfg_wdata[N-1:0])))
        else $error("fiq_select write lost");

endmodule

/* src/vic_prio.sv */
`timescale 1ns / 1ps
// Lowest-set-bit priority encoder over the IRQ status vector.
// Depends on vic_pkg.
module vic_prio #(
    parameter int NUM_SOURCES = vic_pkg::NUM_SOURCES_DEF
) (
    input  logic [NUM_SOURCES-1:0]        i_vec,
    output logic [vic_pkg::PIDX_W-1:0]    o_index,
    output logic                          o_valid
);
    import vic_pkg::*;

    localparam int IDX_W = $clog2(NUM_SOURCES);

    logic [IDX_W-1:0] w_idx;

    always_comb begin
        w_idx = '0;
        for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                w_idx = IDX_W'(i);
            end
        end
    end

    assign o_index = PIDX_W'(w_idx);
    assign o_valid = |i_vec;

endmodule

/* src/vic_obuf.sv */
`timescale 1ns / 1ps
// Output register with one skid entry; decouples downstream stalls from input ready.
// Depends on vic_pkg.
module vic_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  vic_pkg::t_result   i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output vic_pkg::t_result   o_data
);
    import vic_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out_data, r_skid_data;
    logic    w_push, w_pop;

    assign o_ready = !r_skid_valid;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = r_out_valid && i_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (w_push) begin
                r_out_data <= i_data;
            end
        end else if (w_push) begin
            if (!r_out_valid) begin
                r_out_data <= i_data;
            end else begin
                r_skid_data <= i_data;
            end
        end
    end

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && r_out_valid && !w_pop) |=> (r_skid_valid && r_skid_data == $past(i_data)))
        else $error("stalled transaction not captured in skid entry");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && r_skid_valid) |=> (r_out_valid && r_out_data == $past(r_skid_data)))
        else $error("skid entry not moved to output register");

endmodule

/* src/vectored_interrupt_controller.sv */
`timescale 1ns / 1ps
// Vectored interrupt controller, top level.
// Depends on vic_pkg, vic_core, vic_prio, vic_obuf.
//
// Usage:
//  - s_axis carries one transaction per item: tuser selects tick (new source
//    levels), bus write, bus read or idle; tdata carries offset, write data, levels.
//  - m_axis returns exactly one result per accepted input: read data, IRQ/FIQ
//    lines and the lowest pending IRQ source index.
//  - i_cfg_* writes level_sense (index 0) and fiq_select (index 1); write only
//    while no transaction is in flight.
// Timing:
//  - State update and result logic are combinational in the handshake cycle;
//    the result is registered in the output stage before it shows on m_axis.
//  - Throughput is one transaction per cycle while m_axis keeps taking results.
// Reset (synchronous, active low) clears all masks, latches and previous levels
// and empties the output stage.
// Stall: while m_axis_tready is low, one more result is held in a skid entry;
// s_axis_tready then drops until m_axis takes the result in the output register.
module vectored_interrupt_controller #(
    parameter int NUM_SOURCES = vic_pkg::NUM_SOURCES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [vic_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vic_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [6:0] reg_offset, [38:7] write_data, [102:39] source_levels, [103] zero
    input  logic [vic_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] action
    input  logic [vic_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] read_data, [32] irq_line, [33] fiq_line, [39:34] pending_index,
    // [40] pending_valid, [47:41] zero
    output logic [vic_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import vic_pkg::*;

    t_item                  w_item;
    t_result                w_result, w_out;
    logic                   w_accept;
    logic [NUM_SOURCES-1:0] w_irq_vec;
    logic [MAX_SOURCES-1:0] w_irq_wide;

    assign w_item.action        = t_action'(s_axis_tuser);
    assign w_item.reg_offset    = s_axis_tdata[OFFSET_W-1:0];
    assign w_item.write_data    = s_axis_tdata[OFFSET_W+HALF_W-1:OFFSET_W];
    assign w_item.source_levels = s_axis_tdata[OFFSET_W+HALF_W+MAX_SOURCES-1:OFFSET_W+HALF_W];

    assign w_accept = s_axis_tvalid && s_axis_tready;

    vic_core #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_item      (w_item),
        .o_read_data (w_result.read_data),
        .o_irq_line  (w_result.irq_line),
        .o_fiq_line  (w_result.fiq_line),
        .o_irq_vec   (w_irq_vec)
    );

    // lowest pending IRQ source, matches ffs dispatch order
    vic_prio #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_prio (
        .i_vec   (w_irq_vec),
        .o_index (w_result.pending_index),
        .o_valid (w_result.pending_valid)
    );

    vic_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (w_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, w_out};

    assign w_irq_wide = MAX_SOURCES'(w_irq_vec);

    a_pending_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result.pending_valid |-> w_irq_wide[w_result.pending_index])
        else $error("pending index does not name a pending source");

    a_pending_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_out.pending_valid == w_out.irq_line))
        else $error("pending_valid disagrees with irq_line");

endmodule

/* sim/vic_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the vectored interrupt controller: watches the config port
// and both streams, predicts every result and compares it. Depends on vic_pkg.
module vic_checker #(
    parameter int NUM_SOURCES = vic_pkg::NUM_SOURCES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vic_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vic_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [vic_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [vic_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [vic_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output int                              o_errors,
    output int                              o_outstanding
);
    import vic_pkg::*;

    localparam logic [MAX_SOURCES-1:0] SRC_MASK =
        {MAX_SOURCES{1'b1}} >> (MAX_SOURCES - NUM_SOURCES);

    // shadow copy of the controller state
    logic [MAX_SOURCES-1:0] level_sense_q  = '0;
    logic [MAX_SOURCES-1:0] fiq_select_q   = '0;
    logic [MAX_SOURCES-1:0] enable_q       = '0;
    logic [MAX_SOURCES-1:0] soft_trig_q    = '0;
    logic [MAX_SOURCES-1:0] edge_latch_q   = '0;
    logic [MAX_SOURCES-1:0] prev_levels_q  = '0;

    t_result expected_reports[$];
    t_result predicted;
    t_result wanted;
    t_result observed;
    int      error_count = 0;

    assign o_errors = error_count;

    function automatic logic [MAX_SOURCES-1:0] raw_pending();
        return ((prev_levels_q & level_sense_q) | edge_latch_q | soft_trig_q) & SRC_MASK;
    endfunction

    function automatic logic [MAX_SOURCES-1:0] read_register(input logic [SEL_W-1:0] sel);
        case (sel)
            SEL_IRQ_STATUS:  return raw_pending() & enable_q & ~fiq_select_q;
            SEL_FIQ_STATUS:  return raw_pending() & enable_q & fiq_select_q;
            SEL_RAW_STATUS:  return raw_pending();
            SEL_FIQ_SELECT:  return fiq_select_q & SRC_MASK;
            SEL_ENABLE:      return enable_q;
            SEL_SOFT:        return soft_trig_q;
            SEL_LEVEL_SENSE: return level_sense_q & SRC_MASK;
            SEL_EDGE_STATUS: return edge_latch_q;
            default:         return '0;
        endcase
    endfunction

    // Updates the shadow state for one transaction and builds its result.
    task automatic apply_transaction(input t_item it, output t_result res);
        logic [MAX_SOURCES-1:0] levels;
        logic [MAX_SOURCES-1:0] bits;
        logic [MAX_SOURCES-1:0] word;
        logic [MAX_SOURCES-1:0] irq;
        logic [MAX_SOURCES-1:0] fiq;
        logic [SEL_W-1:0]       sel;
        int                     shift;
        sel    = it.reg_offset[6:3];
        shift  = it.reg_offset[2] ? HALF_W : 0;
        levels = it.source_levels & SRC_MASK;
        res    = '0;
        case (it.action)
            ACT_TICK: begin
                edge_latch_q  |= levels & ~prev_levels_q & ~level_sense_q & SRC_MASK;
                prev_levels_q  = levels;
            end
            ACT_WRITE: begin
                bits = (64'(it.write_data) << shift) & SRC_MASK;
                case (sel)
                    SEL_ENABLE:     enable_q     |= bits;
                    SEL_ENABLE_CLR: enable_q     &= ~bits;
                    SEL_SOFT:       soft_trig_q  |= bits;
                    SEL_SOFT_CLR:   soft_trig_q  &= ~bits;
                    SEL_EDGE_CLR:   edge_latch_q &= ~bits;
                    default: ;
                endcase
            end
            ACT_READ: begin
                word          = read_register(sel) >> shift;
                res.read_data = word[HALF_W-1:0];
            end
            default: ;
        endcase
        irq = read_register(SEL_IRQ_STATUS);
        fiq = read_register(SEL_FIQ_STATUS);
        res.irq_line      = |irq;
        res.fiq_line      = |fiq;
        res.pending_valid = |irq;
        for (int i = MAX_SOURCES - 1; i >= 0; i--) begin
            if (irq[i]) res.pending_index = PIDX_W'(i);
        end
    endtask

    function automatic int field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            level_sense_q = '0;
            fiq_select_q  = '0;
            enable_q      = '0;
            soft_trig_q   = '0;
            edge_latch_q  = '0;
            prev_levels_q = '0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LEVEL_SENSE) level_sense_q = i_cfg_wdata;
                else if (i_cfg_index == CFG_FIQ_SELECT) fiq_select_q = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                apply_transaction(t_item'({s_axis_tuser, s_axis_tdata[IN_TDATA_W-2:0]}),
                                  predicted);
                expected_reports.push_back(predicted);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                observed = t_result'(m_axis_tdata[RESULT_W-1:0]);
                if (expected_reports.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %0h",
                             $time, observed);
                    error_count++;
                end else begin
                    wanted = expected_reports.pop_front();
                    error_count += field_mismatch("read_data", wanted.read_data,
                                                  observed.read_data);
                    error_count += field_mismatch("irq_line", wanted.irq_line,
                                                  observed.irq_line);
                    error_count += field_mismatch("fiq_line", wanted.fiq_line,
                                                  observed.fiq_line);
                    error_count += field_mismatch("pending_index", wanted.pending_index,
                                                  observed.pending_index);
                    error_count += field_mismatch("pending_valid", wanted.pending_valid,
                                                  observed.pending_valid);
                end
            end
        end
        o_outstanding <= expected_reports.size();
    end

endmodule

/* sim/vectored_interrupt_controller_tb.sv */
`timescale 1ns / 1ps
// Top of the vectored interrupt controller testbench: clock, reset, stimulus
// and verdict. Depends on vic_pkg, vic_checker and the controller RTL.
module vectored_interrupt_controller_tb;
    import vic_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;  // far above the slowest legal run
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int DRAIN_CYCLES    = 4;       // extra drain wait after the last result is back
    localparam int MAX_GAP         = 10;

    localparam logic [MAX_SOURCES-1:0] ALL_SOURCES = {MAX_SOURCES{1'b1}};
    localparam logic [HALF_W-1:0]      ALL_BITS    = {HALF_W{1'b1}};

    // register selects the package leaves out
    localparam logic [SEL_W-1:0] SEL_DUAL_EDGE = 4'h9;
    localparam logic [SEL_W-1:0] SEL_EVENT_POL = 4'hA;
    localparam logic [SEL_W-1:0] SEL_UNMAPPED  = 4'hF;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int                     errors;
    int                     outstanding;
    int                     cycle_count   = 0;
    bit                     no_idle       = 1'b0;  // burst phase: neither side idles
    logic [MAX_SOURCES-1:0] last_levels   = '0;    // levels of the last tick sent

    vectored_interrupt_controller u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [6:0] reg_offset, [38:7] write_data, [102:39] source_levels, [103] zero
        .s_axis_tdata  (s_axis_tdata),
        // [1:0] action
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [31:0] read_data, [32] irq_line, [33] fiq_line, [39:34] pending_index,
        // [40] pending_valid, [47:41] zero
        .m_axis_tdata  (m_axis_tdata)
    );

    vic_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // byte offset of a register half
    function automatic logic [OFFSET_W-1:0] reg_addr(input logic [SEL_W-1:0] sel,
                                                     input logic high);
        return {sel, high, 2'b00};
    endfunction

    // few bits set, so the priority encoder sees varied lowest indexes
    function automatic logic [HALF_W-1:0] sparse_word();
        return $urandom & $urandom & $urandom;
    endfunction

    function automatic logic [MAX_SOURCES-1:0] pick_mask();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return ALL_SOURCES;
            2:       return {sparse_word(), sparse_word()};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // One input transaction. Holds tvalid low for a random gap first, then
    // presents the item and returns on the edge where it is accepted. tvalid
    // stays high afterwards so back-to-back items need no extra assignment.
    task automatic send_item(input t_action act, input logic [OFFSET_W-1:0] off,
                             input logic [HALF_W-1:0] wdata,
                             input logic [MAX_SOURCES-1:0] levels);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, levels, wdata, off};
        s_axis_tuser  <= act;
        if (act == ACT_TICK) last_levels = levels;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop the stream, wait until every result is back plus the drain
    // wait, then load both routing registers on consecutive cycles.
    task automatic load_routing(input logic [MAX_SOURCES-1:0] level_sense,
                                input logic [MAX_SOURCES-1:0] fiq_select);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LEVEL_SENSE;
        i_cfg_wdata <= level_sense;
        @(posedge i_clk);
        i_cfg_index <= CFG_FIQ_SELECT;
        i_cfg_wdata <= fiq_select;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly meaningful traffic: ticks that toggle a few sources, write-1
    // accesses to the set/clear registers, reads of every register. The rest
    // is any offset at all and the idle action.
    task automatic send_random_item();
        int                     pick;
        logic [SEL_W-1:0]       sel;
        logic [OFFSET_W-1:0]    off;
        logic [HALF_W-1:0]      wdata;
        logic [MAX_SOURCES-1:0] levels;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            case ($urandom_range(0, 9))
                0:       levels = '0;
                1:       levels = ALL_SOURCES;
                2:       levels = {$urandom, $urandom};
                3:       levels = last_levels;
                default: levels = last_levels ^ {sparse_word(), sparse_word()};
            endcase
            send_item(ACT_TICK, OFFSET_W'($urandom), $urandom, levels);
        end else if (pick < 65) begin
            case ($urandom_range(0, 5))
                0, 1:    sel = SEL_ENABLE;
                2:       sel = SEL_ENABLE_CLR;
                3:       sel = SEL_SOFT;
                4:       sel = SEL_SOFT_CLR;
                default: sel = SEL_EDGE_CLR;
            endcase
            off = ($urandom_range(0, 9) == 0) ? OFFSET_W'($urandom)
                                              : {sel, 1'($urandom), 2'($urandom)};
            wdata = ($urandom_range(0, 3) == 0) ? $urandom : sparse_word();
            send_item(ACT_WRITE, off, wdata, {$urandom, $urandom});
        end else if (pick < 95) begin
            sel = SEL_W'($urandom_range(SEL_IRQ_STATUS, SEL_EDGE_STATUS));
            off = ($urandom_range(0, 7) == 0) ? OFFSET_W'($urandom)
                                              : {sel, 1'($urandom), 2'($urandom)};
            send_item(ACT_READ, off, $urandom, {$urandom, $urandom});
        end else begin
            send_item(ACT_IDLE, OFFSET_W'($urandom), $urandom, {$urandom, $urandom});
        end
    endtask

    // Result side: a random stall per result, tready held high until the
    // next result transaction is taken.
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: all sources edge latched and routed to IRQ ---
        load_routing('0, '0);
        send_item(ACT_READ,  reg_addr(SEL_IRQ_STATUS, 1'b0), '0, '0);
        send_item(ACT_WRITE, reg_addr(SEL_ENABLE, 1'b0), ALL_BITS, '0);
        send_item(ACT_WRITE, reg_addr(SEL_ENABLE, 1'b1), ALL_BITS, '0);
        // every source rises: all sources latch an edge, lowest pending is source 0
        send_item(ACT_TICK,  '0, '0, ALL_SOURCES);
        // offset bits 1..0 are don't-care
        send_item(ACT_READ,  {SEL_RAW_STATUS, 1'b1, 2'b11}, '0, '0);
        send_item(ACT_READ,  reg_addr(SEL_EDGE_STATUS, 1'b0), '0, '0);
        // falling levels leave the latches alone
        send_item(ACT_TICK,  '0, '0, '0);
        send_item(ACT_WRITE, reg_addr(SEL_EDGE_CLR, 1'b0), ALL_BITS, '0);
        // leave only source 63 latched: top index of the encoder
        send_item(ACT_WRITE, reg_addr(SEL_EDGE_CLR, 1'b1), 32'h7FFF_FFFF, '0);
        send_item(ACT_WRITE, reg_addr(SEL_ENABLE_CLR, 1'b1), 32'h8000_0000, '0);
        send_item(ACT_WRITE, reg_addr(SEL_SOFT, 1'b0), 32'h0000_0001, '0);
        send_item(ACT_WRITE, reg_addr(SEL_SOFT_CLR, 1'b0), ALL_BITS, '0);
        // write-only, dual edge, polarity and unmapped registers read zero
        send_item(ACT_READ,  reg_addr(SEL_ENABLE_CLR, 1'b0), '0, '0);
        send_item(ACT_READ,  reg_addr(SEL_DUAL_EDGE, 1'b0), '0, '0);
        send_item(ACT_READ,  reg_addr(SEL_EVENT_POL, 1'b1), '0, '0);
        send_item(ACT_READ,  {SEL_UNMAPPED, 1'b1, 2'b11}, '0, '0);
        // writes to read-only offsets change nothing
        send_item(ACT_WRITE, reg_addr(SEL_IRQ_STATUS, 1'b0), ALL_BITS, '0);
        send_item(ACT_WRITE, reg_addr(SEL_LEVEL_SENSE, 1'b0), ALL_BITS, '0);
        send_item(ACT_WRITE, reg_addr(SEL_FIQ_SELECT, 1'b1), ALL_BITS, '0);
        send_item(ACT_IDLE,  reg_addr(SEL_ENABLE, 1'b0), ALL_BITS, ALL_SOURCES);

        // --- directed: everything level sensed and routed to FIQ ---
        load_routing(ALL_SOURCES, ALL_SOURCES);
        send_item(ACT_TICK,  '0, '0, ALL_SOURCES);
        send_item(ACT_READ,  reg_addr(SEL_FIQ_STATUS, 1'b1), '0, '0);
        send_item(ACT_READ,  reg_addr(SEL_FIQ_SELECT, 1'b0), '0, '0);
        send_item(ACT_READ,  reg_addr(SEL_LEVEL_SENSE, 1'b1), '0, '0);
        // level-sensed status follows the source straight back down
        send_item(ACT_TICK,  '0, '0, '0);

        // --- random phases, new routing each time, some with no idling ---
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            load_routing(pick_mask(), pick_mask());
            repeat (ITEMS_PER_PHASE) send_random_item();
        end

        // wait for the last results, then drain
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/vic_pkg.sv
src/vic_core.sv
src/vic_prio.sv
src/vic_obuf.sv
src/vectored_interrupt_controller.sv
sim/vic_checker.sv
sim/vectored_interrupt_controller_tb.sv
